>>> src/prl_pkg.sv
// ----------------------------------------------------------------------------
// prl_pkg
// Shared types and constants of the per-source packet rate limiter.
// ----------------------------------------------------------------------------
package prl_pkg;

  // Number of slots in the direct-mapped table. This must be a power of two,
  // because the slot index is taken from the low address bits.
  localparam int unsigned TABLE_SLOTS = 32;
  localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned WLEN_W  = 32;
  localparam int unsigned MAXP_W  = 16;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(1000000);
  localparam logic [MAXP_W-1:0] MAXP_RESET = MAXP_W'(2000);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 2'd0,
    CFG_MAX_PACKETS   = 2'd1
  } cfg_index_e;

  // One table entry as stored in the slot memory.
  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  win_origin;
  } slot_entry_t;

  localparam int unsigned ENTRY_W = $bits(slot_entry_t);

  // Result of the update for one item.
  typedef struct packed {
    slot_entry_t entry;
    logic        allowed;
  } slot_update_t;

endpackage

>>> src/per_source_packet_rate_limiter.sv
// ----------------------------------------------------------------------------
// per_source_packet_rate_limiter
// Fixed-window per-source packet policer over a direct-mapped slot table.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i/in_ready_o) carries one item per packet: its
// source address and the current microsecond time. The output channel
// (out_valid_o/out_ready_i) returns one item per input item, in order, with
// allowed_o set when the packet passes.
// The slot memory is read at the acceptance edge, the compute stage then
// computes the decision, and once the output register is free or draining
// the slot is written back and the output register loaded at the same edge.
// The sustained rate is one item per cycle while the receiver does not stall. A packet
// that hits the slot written at its own acceptance edge takes the written
// entry from a forwarding register, since the memory read at that edge
// still returns the old contents.
// Reset clears the slot valid bits at once, so every slot reads as zero
// (address, count and window start) until it is first written; no clearing
// pass is needed. The configuration registers return to a window of
// 1000000 us and a limit of 2000 packets.
// When the receiver stalls, the result waits in the output register, the
// next item waits in the compute stage, and in_ready_o drops until the
// output register drains.
// ----------------------------------------------------------------------------
module per_source_packet_rate_limiter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [prl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [prl_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [prl_pkg::ADDR_W-1:0]       source_address_i,
  input  logic [prl_pkg::TIME_W-1:0]       time_now_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             allowed_o
);
  import prl_pkg::*;

  // Configuration registers.
  logic [WLEN_W-1:0] window_length_q;
  logic [MAXP_W-1:0] max_packets_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= WLEN_RESET;
      max_packets_q   <= MAXP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WINDOW_LENGTH: window_length_q <= cfg_data_i[WLEN_W-1:0];
        CFG_MAX_PACKETS:   max_packets_q   <= cfg_data_i[MAXP_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and stage control.
  logic              b_valid_q;
  logic              out_valid_q;
  logic              allowed_q;
  logic              b_adv;
  logic              in_accept;
  logic [SLOT_W-1:0] in_idx;

  assign b_adv      = b_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !b_valid_q || b_adv;
  assign in_accept  = in_valid_i && in_ready_o;
  assign in_idx     = source_address_i[SLOT_W-1:0];

  // Compute stage: holds the item while its slot is read.
  logic [ADDR_W-1:0] b_addr_q;
  logic [TIME_W-1:0] b_time_q;
  logic [SLOT_W-1:0] b_idx_q;
  logic              b_slot_vld_q;
  logic              b_fwd_q;

  // Per-slot valid bits; a slot never written reads as all zero.
  logic [TABLE_SLOTS-1:0] slot_vld_q;

  // Forwarding register: the entry written at the acceptance edge.
  slot_entry_t       fwd_entry_q;
  logic [SLOT_W-1:0] fwd_idx_q;

  logic [ENTRY_W-1:0] ram_rdata;
  slot_entry_t        rd_entry;
  slot_entry_t        cur_entry;
  slot_update_t       upd;

  prl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (b_adv),
    .waddr_i (b_idx_q),
    .wdata_i (upd.entry),
    .re_i    (in_accept),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    rd_entry = slot_entry_t'(ram_rdata);
    if (b_fwd_q && (fwd_idx_q == b_idx_q)) begin
      cur_entry = fwd_entry_q;
    end else if (b_slot_vld_q) begin
      cur_entry = rd_entry;
    end else begin
      cur_entry = '0;
    end
  end

  prl_update u_update (
    .entry_i          (cur_entry),
    .source_address_i (b_addr_q),
    .time_now_i       (b_time_q),
    .window_length_i  (window_length_q),
    .max_packets_i    (max_packets_q),
    .update_o         (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      slot_vld_q  <= '0;
    end else begin
      if (in_accept) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_adv) begin
        out_valid_q         <= 1'b1;
        slot_vld_q[b_idx_q] <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      b_addr_q     <= source_address_i;
      b_time_q     <= time_now_i;
      b_idx_q      <= in_idx;
      b_slot_vld_q <= slot_vld_q[in_idx];
      b_fwd_q      <= b_adv;
    end
    if (b_adv) begin
      allowed_q   <= upd.allowed;
      fwd_entry_q <= upd.entry;
      fwd_idx_q   <= b_idx_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign allowed_o   = allowed_q;

  // A stalled compute stage keeps its item.
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !b_adv) |=> b_valid_q)
    else $error("compute stage lost an item while stalled");

  // An item is only accepted when the compute stage is free or draining.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (!b_valid_q || b_adv))
    else $error("compute stage overwritten");

  // A written slot is marked valid from the next cycle on.
  a_slot_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_adv |=> slot_vld_q[$past(b_idx_q)])
    else $error("written slot not marked valid");

  // Every write-back leaves a nonzero count.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_adv |-> (upd.entry.count != '0))
    else $error("slot written with zero count");

endmodule

>>> src/prl_ram.sv
// ----------------------------------------------------------------------------
// prl_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module prl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/prl_update.sv
// ----------------------------------------------------------------------------
// prl_update
// Fixed-window decision and new slot contents for one packet.
// ----------------------------------------------------------------------------
module prl_update (
  input  prl_pkg::slot_entry_t             entry_i,
  input  logic [prl_pkg::ADDR_W-1:0]       source_address_i,
  input  logic [prl_pkg::TIME_W-1:0]       time_now_i,
  input  logic [prl_pkg::WLEN_W-1:0]       window_length_i,
  input  logic [prl_pkg::MAXP_W-1:0]       max_packets_i,
  output prl_pkg::slot_update_t            update_o
);
  import prl_pkg::*;

  logic [TIME_W-1:0]  elapsed;
  logic               expired;
  logic [COUNT_W-1:0] count_inc;

  always_comb begin
    elapsed   = time_now_i - entry_i.win_origin;
    expired   = elapsed > {{(TIME_W-WLEN_W){1'b0}}, window_length_i};
    count_inc = (entry_i.count == COUNT_MAX) ? COUNT_MAX : entry_i.count + COUNT_ONE;

    update_o.entry.address = source_address_i;
    if ((entry_i.address != source_address_i) || expired) begin
      // Slot taken over or window over: start a fresh window.
      update_o.entry.count      = COUNT_ONE;
      update_o.entry.win_origin = time_now_i;
      update_o.allowed          = 1'b1;
    end else begin
      update_o.entry.count      = count_inc;
      update_o.entry.win_origin = entry_i.win_origin;
      update_o.allowed = count_inc <= {{(COUNT_W-MAXP_W){1'b0}}, max_packets_i};
    end
  end

endmodule
